### design/rsdp_pkg.sv
package rsdp_pkg;

   localparam int MAX_PARTICLES_DEF = 4096;
   localparam int MAX_BINS_DEF      = 64;

   // floor(2^26 * 1e10 / pi)
   localparam logic [57:0] INV_PI_K = 58'd213614148617634871;

   localparam logic [31:0] BIN_SIZE_RST       = 32'd65536;
   localparam logic [6:0]  NUM_BINS_RST       = 7'd64;
   localparam logic [31:0] HALF_THICKNESS_RST = 32'd163840;

   typedef enum logic [2:0] {
      REG_BIN_SIZE       = 3'd0,
      REG_NUM_BINS       = 3'd1,
      REG_CENTROID_GIVEN = 3'd2,
      REG_CENTROID_X     = 3'd3,
      REG_CENTROID_Y     = 3'd4,
      REG_CENTROID_Z     = 3'd5,
      REG_HALF_THICKNESS = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [31:0] bin_size;
      logic [6:0]  num_bins;
      logic        centroid_given;
      logic [31:0] centroid_x;
      logic [31:0] centroid_y;
      logic [31:0] centroid_z;
      logic [31:0] half_thickness;
   } cfg_type;

   typedef struct packed {
      logic [63:0] mom_x;
      logic [63:0] mom_y;
      logic [63:0] mom_z;
      logic [43:0] mass_sum;
   } job_type;

   typedef enum logic [4:0] {
      B_IDLE, B_CENT, B_CDIV, B_SETUP, B_PRD, B_PLD, B_PMUL, B_PSUM, B_PSQ,
      B_PQI, B_PQ, B_BRD, B_BWR, B_DRD, B_DLD, B_DM0, B_DM1, B_DSUM, B_DDIV,
      B_EMIT
   } back_state_type;

   function automatic logic [43:0] sat_add44(input logic [43:0] a, input logic [43:0] b);
      logic [44:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[44] ? {44{1'b1}} : s[43:0];
   endfunction

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

endpackage

### design/rsdp_div.sv
module rsdp_div #(
   parameter int NW = 102,
   parameter int DW = 73
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quot
);

   localparam int CNTW = $clog2(NW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [DW:0]     rem_ff, rem_in;
   logic [NW-1:0]   n_ff, n_in;
   logic [DW-1:0]   d_ff, d_in;
   logic [NW-1:0]   q_ff, q_in;
   logic [DW+1:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      n_in    = n_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      trial   = {rem_ff, n_ff[NW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(NW);
         rem_in  = '0;
         n_in    = num;
         d_in    = den;
         q_in    = '0;
      end else if (busy_ff) begin
         n_in = n_ff << 1;
         if (trial >= {2'b00, d_ff}) begin
            rem_in = (DW+1)'(trial - {2'b00, d_ff});
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW:0];
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      n_ff   <= n_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

### design/rsdp_front.sv
module rsdp_front #(
   parameter int  MAX_PARTICLES = rsdp_pkg::MAX_PARTICLES_DEF,
   localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1,
   localparam int CW = $clog2(MAX_PARTICLES + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [31:0]         req_pos_x,
   input  logic [31:0]         req_pos_y,
   input  logic [31:0]         req_pos_z,
   input  logic [31:0]         req_mass,
   input  logic                req_last,
   output logic                pw_en,
   output logic [AW-1:0]       pw_addr,
   output logic [127:0]        pw_data,
   output logic                job_valid,
   output rsdp_pkg::job_type   job,
   output logic [CW-1:0]       job_count,
   input  logic                job_take,
   input  logic                back_done
);

   logic                 hold_ff, hold_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 s1_vld_ff, s1_vld_in;
   logic                 s1_last_ff, s1_last_in;
   logic                 s1_st_ff, s1_st_in;
   logic [63:0]          s1_px_ff, s1_py_ff, s1_pz_ff;
   logic [31:0]          s1_m_ff;
   logic [CW-1:0]        s1_cnt_ff, s1_cnt_in;
   rsdp_pkg::job_type    sum_ff, sum_in, sum_nx;
   logic                 jv_ff, jv_in;
   rsdp_pkg::job_type    job_ff, job_in;
   logic [CW-1:0]        jcnt_ff, jcnt_in;
   logic                 accept, stored;
   logic signed [64:0]   px, py, pz;

   assign accept = req_valid && req_ready;
   assign stored = (32'(cnt_ff) < MAX_PARTICLES);
   assign px = $signed(req_pos_x) * $signed({1'b0, req_mass});
   assign py = $signed(req_pos_y) * $signed({1'b0, req_mass});
   assign pz = $signed(req_pos_z) * $signed({1'b0, req_mass});

   always_comb begin
      hold_in    = hold_ff;
      cnt_in     = cnt_ff;
      s1_vld_in  = accept;
      s1_last_in = req_last;
      s1_st_in   = stored;
      s1_cnt_in  = cnt_ff + CW'(stored);
      sum_in     = sum_ff;
      jv_in      = jv_ff && !job_take;
      job_in     = job_ff;
      jcnt_in    = jcnt_ff;
      sum_nx     = sum_ff;
      if (s1_st_ff) begin
         sum_nx.mom_x    = rsdp_pkg::sat_add64(sum_ff.mom_x, s1_px_ff);
         sum_nx.mom_y    = rsdp_pkg::sat_add64(sum_ff.mom_y, s1_py_ff);
         sum_nx.mom_z    = rsdp_pkg::sat_add64(sum_ff.mom_z, s1_pz_ff);
         sum_nx.mass_sum = rsdp_pkg::sat_add44(sum_ff.mass_sum, {12'd0, s1_m_ff});
      end
      if (back_done) begin
         hold_in = 1'b0;
      end
      if (accept) begin
         cnt_in = req_last ? '0 : s1_cnt_in;
         if (req_last) begin
            hold_in = 1'b1;
         end
      end
      if (s1_vld_ff) begin
         sum_in = sum_nx;
         if (s1_last_ff) begin
            sum_in  = '0;
            job_in  = sum_nx;
            jcnt_in = s1_cnt_ff;
            jv_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff   <= 1'b0;
         cnt_ff    <= '0;
         s1_vld_ff <= 1'b0;
         sum_ff    <= '0;
         jv_ff     <= 1'b0;
      end else begin
         hold_ff   <= hold_in;
         cnt_ff    <= cnt_in;
         s1_vld_ff <= s1_vld_in;
         sum_ff    <= sum_in;
         jv_ff     <= jv_in;
      end
      s1_last_ff <= s1_last_in;
      s1_st_ff   <= s1_st_in;
      s1_cnt_ff  <= s1_cnt_in;
      s1_px_ff   <= px[63:0];
      s1_py_ff   <= py[63:0];
      s1_pz_ff   <= pz[63:0];
      s1_m_ff    <= req_mass;
      job_ff     <= job_in;
      jcnt_ff    <= jcnt_in;
   end

   assign req_ready = !hold_ff;
   assign pw_en     = accept && stored;
   assign pw_addr   = cnt_ff[AW-1:0];
   assign pw_data   = {req_pos_x, req_pos_y, req_pos_z, req_mass};
   assign job_valid = jv_ff;
   assign job       = job_ff;
   assign job_count = jcnt_ff;

endmodule

### design/rsdp_back.sv
module rsdp_back #(
   parameter int  MAX_PARTICLES = rsdp_pkg::MAX_PARTICLES_DEF,
   parameter int  MAX_BINS      = rsdp_pkg::MAX_BINS_DEF,
   localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1,
   localparam int CW = $clog2(MAX_PARTICLES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  rsdp_pkg::cfg_type cfg,
   input  logic              pw_en,
   input  logic [AW-1:0]     pw_addr,
   input  logic [127:0]      pw_data,
   input  logic              job_valid,
   input  rsdp_pkg::job_type job,
   input  logic [CW-1:0]     job_count,
   output logic              job_take,
   output logic              back_done,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [5:0]        rsp_bin_index,
   output logic [63:0]       rsp_density,
   output logic [43:0]       rsp_disk_mass,
   output logic              rsp_no_mass,
   output logic              rsp_last_bin
);

   localparam int QW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int BW = $clog2(MAX_BINS + 1);
   localparam int FW = $clog2(8 * MAX_BINS);
   localparam int DW = 64 + FW;
   localparam int NW = 102;
   localparam int TW = 36 + QW;

   logic [127:0] pmem [MAX_PARTICLES];
   logic [127:0] prd_ff;
   logic         prd_en;
   logic [AW-1:0] prd_addr;
   logic [43:0]  bmem [MAX_BINS];
   logic [43:0]  brd_ff;
   logic         bre, bwe;
   logic [QW-1:0] bra, bwa;
   logic [43:0]  bwd;
   logic [MAX_BINS-1:0] bvld_ff, bvld_in;
   logic         brv_ff, brv_in;

   rsdp_pkg::back_state_type st_ff, st_in;
   rsdp_pkg::job_type job_ff, job_in;
   logic [CW-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic [31:0]  cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic         nom_ff, nom_in;
   logic [1:0]   axis_ff, axis_in;
   logic [31:0]  b_ff, b_in;
   logic [63:0]  bb_ff, bb_in;
   logic [BW-1:0] nb_ff, nb_in;
   logic [31:0]  dx_ff, dx_in, dy_ff, dy_in, pm_ff, pm_in;
   logic [63:0]  sx_ff, sx_in, sy_ff, sy_in;
   logic [67:0]  sqv_ff, sqv_in;
   logic [36:0]  sqr_ff, sqr_in;
   logic [33:0]  root_ff, root_in;
   logic [5:0]   step_ff, step_in;
   logic [34:0]  rem_ff, rem_in;
   logic [31+QW:0] dd_ff, dd_in;
   logic [QW-1:0] j_ff, j_in, bin_ff, bin_in;
   logic [43:0]  m_ff, m_in, cum_ff, cum_in;
   logic [72:0]  p0_ff, p0_in, p1_ff, p1_in;
   logic [DW-1:0] den_ff, den_in;
   logic [63:0]  dens_ff, dens_in;
   logic         ov_ff, ov_in;
   logic [5:0]   obin_ff, obin_in;
   logic [63:0]  odens_ff, odens_in;
   logic [43:0]  ocum_ff, ocum_in;
   logic         onom_ff, onom_in, olast_ff, olast_in;

   logic          div_start, div_done;
   logic [NW-1:0] div_num, div_quot;
   logic [DW-1:0] div_den;

   logic [63:0]  mom, mag, qmag;
   logic [31:0]  coord;
   logic [32:0]  dz, dxs, dys;
   logic [31:0]  az, ax, ay;
   logic [36:0]  r2, trial;
   logic [34:0]  tt;
   logic [32:0]  d2;
   logic [43:0]  old;
   logic [FW-1:0] f;
   logic         lastb;

   rsdp_div #(.NW(NW), .DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (pw_en) begin
         pmem[pw_addr] <= pw_data;
      end
      if (prd_en) begin
         prd_ff <= pmem[prd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (bwe) begin
         bmem[bwa] <= bwd;
      end
      if (bre) begin
         brd_ff <= bmem[bra];
      end
   end

   always_comb begin
      st_in = st_ff; job_in = job_ff; cnt_in = cnt_ff; idx_in = idx_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; nom_in = nom_ff; axis_in = axis_ff;
      b_in = b_ff; bb_in = bb_ff; nb_in = nb_ff; dx_in = dx_ff; dy_in = dy_ff;
      pm_in = pm_ff; sx_in = sx_ff; sy_in = sy_ff; sqv_in = sqv_ff; sqr_in = sqr_ff;
      root_in = root_ff; step_in = step_ff; rem_in = rem_ff; dd_in = dd_ff;
      j_in = j_ff; bin_in = bin_ff; m_in = m_ff; cum_in = cum_ff; p0_in = p0_ff;
      p1_in = p1_ff; den_in = den_ff; dens_in = dens_ff; bvld_in = bvld_ff;
      brv_in = brv_ff; ov_in = ov_ff && !rsp_ready; obin_in = obin_ff;
      odens_in = odens_ff; ocum_in = ocum_ff; onom_in = onom_ff; olast_in = olast_ff;
      job_take = 1'b0; back_done = 1'b0; prd_en = 1'b0; prd_addr = idx_ff[AW-1:0];
      bre = 1'b0; bra = j_ff; bwe = 1'b0; bwa = j_ff; bwd = '0;
      div_start = 1'b0; div_num = '0; div_den = DW'(job_ff.mass_sum);

      case (axis_ff)
         2'd0:    mom = job_ff.mom_x;
         2'd1:    mom = job_ff.mom_y;
         default: mom = job_ff.mom_z;
      endcase
      mag  = mom[63] ? (64'd0 - mom) : mom;
      qmag = div_quot[63:0];
      if (!mom[63]) begin
         coord = (qmag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qmag[31:0];
      end else begin
         coord = (qmag > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - qmag);
      end
      dz  = {prd_ff[31+32], prd_ff[63:32]} - {cz_ff[31], cz_ff};
      az  = dz[32] ? 32'(33'd0 - dz) : dz[31:0];
      dxs = {cx_ff[31], cx_ff} - {prd_ff[127], prd_ff[127:96]};
      ax  = dxs[32] ? 32'(33'd0 - dxs) : dxs[31:0];
      dys = {cy_ff[31], cy_ff} - {prd_ff[95], prd_ff[95:64]};
      ay  = dys[32] ? 32'(33'd0 - dys) : dys[31:0];
      r2    = {sqr_ff[34:0], sqv_ff[67:66]};
      trial = {1'b0, root_ff, 2'b01};
      tt    = 35'(root_ff) + 35'(b_ff);
      d2    = {b_ff, 1'b0};
      old   = bvld_ff[j_ff] ? brd_ff : 44'd0;
      f     = (bin_ff == '0) ? FW'(1) : FW'({bin_ff, 3'b000});
      lastb = (32'(bin_ff) + 32'd1 == 32'(nb_ff));

      case (st_ff)
         rsdp_pkg::B_IDLE: begin
            if (job_valid) begin
               job_take = 1'b1;
               job_in   = job;
               cnt_in   = job_count;
               axis_in  = 2'd0;
               nom_in   = 1'b0;
               st_in    = rsdp_pkg::B_CENT;
            end
         end
         rsdp_pkg::B_CENT: begin
            if (cfg.centroid_given) begin
               cx_in = cfg.centroid_x; cy_in = cfg.centroid_y; cz_in = cfg.centroid_z;
               st_in = rsdp_pkg::B_SETUP;
            end else if (job_ff.mass_sum == '0) begin
               cx_in = '0; cy_in = '0; cz_in = '0; nom_in = 1'b1;
               st_in = rsdp_pkg::B_SETUP;
            end else begin
               div_start = 1'b1;
               div_num   = NW'(mag);
               st_in     = rsdp_pkg::B_CDIV;
            end
         end
         rsdp_pkg::B_CDIV: begin
            if (div_done) begin
               case (axis_ff)
                  2'd0:    cx_in = coord;
                  2'd1:    cy_in = coord;
                  default: cz_in = coord;
               endcase
               if (axis_ff == 2'd2) begin
                  st_in = rsdp_pkg::B_SETUP;
               end else begin
                  axis_in = axis_ff + 2'd1;
                  st_in   = rsdp_pkg::B_CENT;
               end
            end
         end
         rsdp_pkg::B_SETUP: begin
            b_in    = (cfg.bin_size == '0) ? 32'd1 : cfg.bin_size;
            bb_in   = 64'(b_in) * 64'(b_in);
            if (cfg.num_bins == '0) begin
               nb_in = BW'(1);
            end else if (32'(cfg.num_bins) > MAX_BINS) begin
               nb_in = BW'(MAX_BINS);
            end else begin
               nb_in = BW'(cfg.num_bins);
            end
            bvld_in = '0;
            idx_in  = '0;
            st_in   = rsdp_pkg::B_PRD;
         end
         rsdp_pkg::B_PRD: begin
            if (idx_ff < cnt_ff) begin
               prd_en = 1'b1;
               st_in  = rsdp_pkg::B_PLD;
            end else begin
               bin_in = '0;
               cum_in = '0;
               st_in  = rsdp_pkg::B_DRD;
            end
         end
         rsdp_pkg::B_PLD: begin
            dx_in = ax;
            dy_in = ay;
            pm_in = prd_ff[31:0];
            if (az > cfg.half_thickness) begin
               idx_in = idx_ff + 1'b1;
               st_in  = rsdp_pkg::B_PRD;
            end else begin
               st_in = rsdp_pkg::B_PMUL;
            end
         end
         rsdp_pkg::B_PMUL: begin
            sx_in = 64'(dx_ff) * 64'(dx_ff);
            sy_in = 64'(dy_ff) * 64'(dy_ff);
            st_in = rsdp_pkg::B_PSUM;
         end
         rsdp_pkg::B_PSUM: begin
            sqv_in  = {1'b0, (65'(sx_ff) + 65'(sy_ff)), 2'b00};
            sqr_in  = '0;
            root_in = '0;
            step_in = 6'd34;
            st_in   = rsdp_pkg::B_PSQ;
         end
         rsdp_pkg::B_PSQ: begin
            sqv_in = sqv_ff << 2;
            if (r2 >= trial) begin
               sqr_in  = r2 - trial;
               root_in = {root_ff[32:0], 1'b1};
            end else begin
               sqr_in  = r2;
               root_in = {root_ff[32:0], 1'b0};
            end
            step_in = step_ff - 6'd1;
            if (step_ff == 6'd1) begin
               st_in = rsdp_pkg::B_PQI;
            end
         end
         rsdp_pkg::B_PQI: begin
            if (TW'(tt) >= (TW'(d2) << QW)) begin
               idx_in = idx_ff + 1'b1;
               st_in  = rsdp_pkg::B_PRD;
            end else begin
               rem_in  = tt;
               dd_in   = (32+QW)'(d2) << (QW - 1);
               j_in    = '0;
               step_in = 6'(QW);
               st_in   = rsdp_pkg::B_PQ;
            end
         end
         rsdp_pkg::B_PQ: begin
            if (TW'(rem_ff) >= TW'(dd_ff)) begin
               rem_in = 35'(TW'(rem_ff) - TW'(dd_ff));
               j_in   = QW'({j_ff, 1'b1});
            end else begin
               j_in = QW'({j_ff, 1'b0});
            end
            dd_in   = dd_ff >> 1;
            step_in = step_ff - 6'd1;
            if (step_ff == 6'd1) begin
               st_in = rsdp_pkg::B_BRD;
            end
         end
         rsdp_pkg::B_BRD: begin
            if (32'(j_ff) < 32'(nb_ff)) begin
               bre   = 1'b1;
               st_in = rsdp_pkg::B_BWR;
            end else begin
               idx_in = idx_ff + 1'b1;
               st_in  = rsdp_pkg::B_PRD;
            end
         end
         rsdp_pkg::B_BWR: begin
            bwe = 1'b1;
            bwd = rsdp_pkg::sat_add44(old, {12'd0, pm_ff});
            bvld_in[j_ff] = 1'b1;
            idx_in = idx_ff + 1'b1;
            st_in  = rsdp_pkg::B_PRD;
         end
         rsdp_pkg::B_DRD: begin
            bre    = 1'b1;
            bra    = bin_ff;
            brv_in = bvld_ff[bin_ff];
            st_in  = rsdp_pkg::B_DLD;
         end
         rsdp_pkg::B_DLD: begin
            m_in   = brv_ff ? brd_ff : 44'd0;
            cum_in = rsdp_pkg::sat_add44(cum_ff, m_in);
            st_in  = rsdp_pkg::B_DM0;
         end
         rsdp_pkg::B_DM0: begin
            p0_in  = 73'(m_ff) * 73'(rsdp_pkg::INV_PI_K[28:0]);
            den_in = DW'(bb_ff) * DW'(f);
            st_in  = rsdp_pkg::B_DM1;
         end
         rsdp_pkg::B_DM1: begin
            p1_in = 73'(m_ff) * 73'(rsdp_pkg::INV_PI_K[57:29]);
            st_in = rsdp_pkg::B_DSUM;
         end
         rsdp_pkg::B_DSUM: begin
            div_start = 1'b1;
            div_num   = NW'(p0_ff) + (NW'(p1_ff) << 29);
            div_den   = den_ff;
            st_in     = rsdp_pkg::B_DDIV;
         end
         rsdp_pkg::B_DDIV: begin
            if (div_done) begin
               dens_in = (div_quot[NW-1:80] != '0) ? {64{1'b1}} : div_quot[79:16];
               st_in   = rsdp_pkg::B_EMIT;
            end
         end
         rsdp_pkg::B_EMIT: begin
            if (!ov_ff || rsp_ready) begin
               ov_in    = 1'b1;
               obin_in  = 6'(bin_ff);
               odens_in = dens_ff;
               ocum_in  = cum_ff;
               onom_in  = nom_ff;
               olast_in = lastb;
               if (lastb) begin
                  back_done = 1'b1;
                  st_in     = rsdp_pkg::B_IDLE;
               end else begin
                  bin_in = bin_ff + 1'b1;
                  st_in  = rsdp_pkg::B_DRD;
               end
            end
         end
         default: st_in = rsdp_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= rsdp_pkg::B_IDLE;
         ov_ff   <= 1'b0;
         bvld_ff <= '0;
      end else begin
         st_ff   <= st_in;
         ov_ff   <= ov_in;
         bvld_ff <= bvld_in;
      end
      job_ff <= job_in; cnt_ff <= cnt_in; idx_ff <= idx_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; nom_ff <= nom_in; axis_ff <= axis_in;
      b_ff <= b_in; bb_ff <= bb_in; nb_ff <= nb_in; dx_ff <= dx_in; dy_ff <= dy_in;
      pm_ff <= pm_in; sx_ff <= sx_in; sy_ff <= sy_in; sqv_ff <= sqv_in; sqr_ff <= sqr_in;
      root_ff <= root_in; step_ff <= step_in; rem_ff <= rem_in; dd_ff <= dd_in;
      j_ff <= j_in; bin_ff <= bin_in; m_ff <= m_in; cum_ff <= cum_in; p0_ff <= p0_in;
      p1_ff <= p1_in; den_ff <= den_in; dens_ff <= dens_in; brv_ff <= brv_in;
      obin_ff <= obin_in; odens_ff <= odens_in; ocum_ff <= ocum_in;
      onom_ff <= onom_in; olast_ff <= olast_in;
   end

   assign rsp_valid     = ov_ff;
   assign rsp_bin_index = obin_ff;
   assign rsp_density   = odens_ff;
   assign rsp_disk_mass = ocum_ff;
   assign rsp_no_mass   = onom_ff;
   assign rsp_last_bin  = olast_ff;

endmodule

### design/radial_surface_density_profile.sv
// Radial surface density profile of a particle disk. Particles are taken one per cycle into a
// particle store until the one flagged last; the block then holds off further transfers while
// it works out the centroid (given, or the mass-weighted mean by three divisions), bins every
// stored particle and emits one result per bin in use. Binning a particle that lands in a bin in
// use takes a 34-step square root plus one step per bin index bit, one outside the disk skips
// both, and each bin's density is then formed by the bit-serial divider.
module radial_surface_density_profile #(
   parameter int MAX_PARTICLES = rsdp_pkg::MAX_PARTICLES_DEF,
   parameter int MAX_BINS      = rsdp_pkg::MAX_BINS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [31:0] req_mass,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_bin_index,
   output logic [63:0] rsp_density,
   output logic [43:0] rsp_disk_mass,
   output logic        rsp_no_mass,
   output logic        rsp_last_bin,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int CW = $clog2(MAX_PARTICLES + 1);

   rsdp_pkg::cfg_type cfg_ff, cfg_in;
   rsdp_pkg::job_type job;
   logic              pw_en, job_valid, job_take, back_done;
   logic [AW-1:0]     pw_addr;
   logic [127:0]      pw_data;
   logic [CW-1:0]     job_count;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            rsdp_pkg::REG_BIN_SIZE:       cfg_in.bin_size       = csr_wdata;
            rsdp_pkg::REG_NUM_BINS:       cfg_in.num_bins       = csr_wdata[6:0];
            rsdp_pkg::REG_CENTROID_GIVEN: cfg_in.centroid_given = csr_wdata[0];
            rsdp_pkg::REG_CENTROID_X:     cfg_in.centroid_x     = csr_wdata;
            rsdp_pkg::REG_CENTROID_Y:     cfg_in.centroid_y     = csr_wdata;
            rsdp_pkg::REG_CENTROID_Z:     cfg_in.centroid_z     = csr_wdata;
            rsdp_pkg::REG_HALF_THICKNESS: cfg_in.half_thickness = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bin_size       <= rsdp_pkg::BIN_SIZE_RST;
         cfg_ff.num_bins       <= rsdp_pkg::NUM_BINS_RST;
         cfg_ff.centroid_given <= 1'b0;
         cfg_ff.centroid_x     <= '0;
         cfg_ff.centroid_y     <= '0;
         cfg_ff.centroid_z     <= '0;
         cfg_ff.half_thickness <= rsdp_pkg::HALF_THICKNESS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rsdp_front #(.MAX_PARTICLES(MAX_PARTICLES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pos_x (req_pos_x),
      .req_pos_y (req_pos_y),
      .req_pos_z (req_pos_z),
      .req_mass  (req_mass),
      .req_last  (req_last),
      .pw_en     (pw_en),
      .pw_addr   (pw_addr),
      .pw_data   (pw_data),
      .job_valid (job_valid),
      .job       (job),
      .job_count (job_count),
      .job_take  (job_take),
      .back_done (back_done)
   );

   rsdp_back #(.MAX_PARTICLES(MAX_PARTICLES), .MAX_BINS(MAX_BINS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .pw_en         (pw_en),
      .pw_addr       (pw_addr),
      .pw_data       (pw_data),
      .job_valid     (job_valid),
      .job           (job),
      .job_count     (job_count),
      .job_take      (job_take),
      .back_done     (back_done),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_bin_index (rsp_bin_index),
      .rsp_density   (rsp_density),
      .rsp_disk_mass (rsp_disk_mass),
      .rsp_no_mass   (rsp_no_mass),
      .rsp_last_bin  (rsp_last_bin)
   );

   a_job_blocks_input: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> !req_ready)
      else $error("particle transfer possible while a set waits for the back end");

   a_store_write_on_transfer: assert property (@(posedge clock) disable iff (reset)
      pw_en |-> (req_valid && req_ready))
      else $error("particle store written without a transfer");

endmodule
